### rtl/atl_pkg.sv
// Shared types, constants and decode functions for the tag lookup block.
// Used by atl_parser, atl_out_reg and aux_tag_lookup; depends on nothing.
package atl_pkg;

  localparam int unsigned MaxRecordLen = 65536;
  localparam int unsigned PosW         = 16;
  localparam int unsigned SkipW        = 17;

  // Saturation point of the byte position and the reported offset.
  localparam logic [PosW-1:0] PosMax =
    (MaxRecordLen - 1 > 65535) ? 16'hFFFF : PosW'(MaxRecordLen - 1);

  // Skip length that means "skip to the end of the record".
  localparam logic [SkipW-1:0] SkipEnd = 17'h1FFFF;

  localparam logic [7:0] CharA = 8'h41;
  localparam logic [7:0] CharB = 8'h42;
  localparam logic [7:0] CharC = 8'h43;
  localparam logic [7:0] CharF = 8'h46;
  localparam logic [7:0] CharI = 8'h49;
  localparam logic [7:0] CharS = 8'h53;
  localparam logic [7:0] CharZ = 8'h5A;

  typedef struct packed {
    logic            valid;
    logic            found;
    logic [PosW-1:0] offset;
  } atl_result_t;

  function automatic logic [7:0] fold_upper(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) r = c - 8'd32;
    return r;
  endfunction

  // Value size in bytes of an already folded type code.
  function automatic logic [2:0] size_of_type(logic [7:0] t);
    logic [2:0] s;
    case (t)
      CharA, CharC: s = 3'd1;
      CharS:        s = 3'd2;
      CharI, CharF: s = 3'd4;
      default:      s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

### rtl/atl_parser.sv
// Tag record parser: one byte per step, key compare and value skipping.
// Depends on atl_pkg.
module atl_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_en_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_i,
  input  logic [15:0]         search_key_i,
  output atl_pkg::atl_result_t res_o
);
  import atl_pkg::*;

  localparam logic [2:0] PhKey0 = 3'd0;
  localparam logic [2:0] PhKey1 = 3'd1;
  localparam logic [2:0] PhType = 3'd2;
  localparam logic [2:0] PhSkip = 3'd3;
  localparam logic [2:0] PhZstr = 3'd4;
  localparam logic [2:0] PhBsub = 3'd5;
  localparam logic [2:0] PhBcnt = 3'd6;

  logic [2:0]       phase_q, phase_d;
  logic [7:0]       held_q, held_d;
  logic [2:0]       elem_q, elem_d;
  logic [23:0]      count_q, count_d;
  logic [SkipW-1:0] skip_q, skip_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             answered_q, answered_d;

  logic             match;
  logic [7:0]       type_c;
  logic [2:0]       type_size;
  logic [34:0]      bytes_total;
  logic [SkipW-1:0] bytes_sat;
  logic [PosW:0]    off_ext;
  logic [PosW-1:0]  off_sat;

  assign type_c    = fold_upper(data_byte_i);
  assign type_size = size_of_type(type_c);

  // Element count times element size; sizes are 0, 1, 2 or 4, so shift.
  always_comb begin
    case (elem_q)
      3'd1:    bytes_total = {3'b000, data_byte_i, count_q};
      3'd2:    bytes_total = {2'b00, data_byte_i, count_q, 1'b0};
      3'd4:    bytes_total = {1'b0, data_byte_i, count_q, 2'b00};
      default: bytes_total = '0;
    endcase
  end

  assign bytes_sat = (bytes_total >= {18'd0, SkipEnd}) ? SkipEnd : bytes_total[SkipW-1:0];

  assign off_ext = {1'b0, pos_q} + 17'd1;
  assign off_sat = (off_ext > {1'b0, PosMax}) ? PosMax : off_ext[PosW-1:0];

  always_comb begin
    phase_d    = phase_q;
    held_d     = held_q;
    elem_d     = elem_q;
    count_d    = count_q;
    skip_d     = skip_q;
    match      = 1'b0;

    if (!answered_q) begin
      unique case (phase_q)
        PhKey0: begin
          held_d  = data_byte_i;
          phase_d = PhKey1;
        end
        PhKey1: begin
          match   = ({held_q, data_byte_i} == search_key_i);
          phase_d = PhType;
        end
        PhType: begin
          if (type_c == CharZ) begin
            phase_d = PhZstr;
          end else if (type_c == CharB) begin
            phase_d = PhBsub;
          end else if (type_size == 3'd0) begin
            phase_d = PhKey0;
          end else begin
            skip_d  = {14'd0, type_size};
            phase_d = PhSkip;
          end
        end
        PhSkip: begin
          if (skip_q != SkipEnd) begin
            skip_d = skip_q - 17'd1;
            if (skip_q == 17'd1) phase_d = PhKey0;
          end
        end
        PhZstr: begin
          if (data_byte_i == 8'd0) phase_d = PhKey0;
        end
        PhBsub: begin
          elem_d  = size_of_type(type_c);
          count_d = '0;
          skip_d  = '0;
          phase_d = PhBcnt;
        end
        PhBcnt: begin
          // Little-endian count; the low skip bits index the count byte.
          case (skip_q[1:0])
            2'd0: count_d[7:0]   = data_byte_i;
            2'd1: count_d[15:8]  = data_byte_i;
            2'd2: count_d[23:16] = data_byte_i;
            default: ;
          endcase
          if (skip_q[1:0] == 2'd3) begin
            if (bytes_total == 35'd0) begin
              skip_d  = '0;
              phase_d = PhKey0;
            end else begin
              skip_d  = bytes_sat;
              phase_d = PhSkip;
            end
          end else begin
            skip_d = skip_q + 17'd1;
          end
        end
        default: phase_d = PhKey0;
      endcase
    end

    answered_d = answered_q | match;
    pos_d      = (pos_q < PosMax) ? pos_q + 16'd1 : pos_q;

    // Last byte: restart for the next record.
    if (last_i) begin
      phase_d    = PhKey0;
      held_d     = '0;
      elem_d     = '0;
      count_d    = '0;
      skip_d     = '0;
      pos_d      = '0;
      answered_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhKey0;
      held_q     <= '0;
      elem_q     <= '0;
      count_q    <= '0;
      skip_q     <= '0;
      pos_q      <= '0;
      answered_q <= 1'b0;
    end else if (step_en_i) begin
      phase_q    <= phase_d;
      held_q     <= held_d;
      elem_q     <= elem_d;
      count_q    <= count_d;
      skip_q     <= skip_d;
      pos_q      <= pos_d;
      answered_q <= answered_d;
    end
  end

  assign res_o.valid  = step_en_i && (match || (last_i && !answered_q));
  assign res_o.found  = match;
  assign res_o.offset = match ? off_sat : '0;

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && last_i |=> phase_q == PhKey0 && pos_q == '0 && !answered_q)
    else $error("parser did not restart after last byte");

  a_bcnt_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhBcnt |-> skip_q < 17'd4)
    else $error("count byte index out of range");

  a_answer_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && match && !last_i |=> answered_q)
    else $error("match not remembered");

  a_one_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    answered_q |-> !match)
    else $error("second match in one record");

endmodule

### rtl/atl_out_reg.sv
// Result register of the tag lookup block, holds one word for the master side.
// Depends on atl_pkg.
module atl_out_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  atl_pkg::atl_result_t      res_i,
  input  logic                      m_axis_tready,
  output logic                      m_axis_tvalid,
  output logic                      found_o,
  output logic [atl_pkg::PosW-1:0]  offset_o
);
  import atl_pkg::*;

  logic            valid_q, valid_d;
  logic            found_q;
  logic [PosW-1:0] offset_q;

  always_comb begin
    valid_d = valid_q;
    if (res_i.valid)        valid_d = 1'b1;
    else if (m_axis_tready) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      found_q  <= res_i.found;
      offset_q <= res_i.offset;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign found_o       = found_q;
  assign offset_o      = offset_q;

endmodule

### rtl/aux_tag_lookup.sv
// Top level of the packed tag record key lookup.
// The result word appears in the cycle after the accepted last-key byte (or last byte).
// Throughput: one record byte per cycle while the result register is empty or drained.
// The parser state steps once per accepted byte; the result register sets the rate.
// Reset (rst_ni low, asynchronous) clears the parser, the result valid and search_key.
// Depends on atl_pkg, atl_parser and atl_out_reg.
module aux_tag_lookup (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: search_key, first character in bits 15:8
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // Slave side: one record byte per word
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last byte of the record
  // Master side: lookup result
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] value_offset
  output logic        m_axis_tuser    // [0] found
);
  import atl_pkg::*;

  logic        [15:0] search_key_q;
  logic               step_en;
  atl_result_t        res;

  // Configuration register; the user must write it only while the block is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_key_q <= '0;
    end else if (cfg_we_i) begin
      search_key_q <= cfg_wdata_i;
    end
  end

  // Take a byte whenever the result register has room for a possible word.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step_en       = s_axis_tvalid && s_axis_tready;

  atl_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_en_i    (step_en),
    .data_byte_i  (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .search_key_i (search_key_q),
    .res_o        (res)
  );

  atl_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .found_o       (m_axis_tuser),
    .offset_o      (m_axis_tdata)
  );

endmodule
